// File: rtl/core/civ_frequency_band_decoder_assert.svh
// Assertion macros shared by the band decoder modules.
`ifndef CIV_FREQUENCY_BAND_DECODER_ASSERT_SVH
`define CIV_FREQUENCY_BAND_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CFBD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfbd assertion failed");

// Next-cycle implication, disabled during reset.
`define CFBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfbd assertion failed");

`endif

// File: rtl/core/cfbd_pkg.sv
// Types, band table and constants of the frequency band decoder.
package cfbd_pkg;

  localparam int unsigned FreqW      = 28;
  localparam int unsigned TableBands = 11;

  localparam logic [7:0] TERMINATOR    = 8'hFD;
  localparam logic [7:0] FREQ_COMMAND  = 8'hA4;
  localparam logic [3:0] CMD_POS       = 4'd3;
  localparam logic [3:0] FIRST_DIG_POS = 4'd5;
  localparam logic [3:0] POS_MAX       = 4'd15;
  localparam logic [3:0] NO_BAND       = 4'd11;

  localparam logic [FreqW-1:0] BAND_LOW [TableBands] = '{
    28'd800000,   28'd3000000,  28'd4500000,  28'd6000000,
    28'd9000000,  28'd13000000, 28'd17000000, 28'd20000000,
    28'd23000000, 28'd27000000, 28'd40000000
  };

  localparam logic [FreqW-1:0] BAND_HIGH [TableBands] = '{
    28'd2999999,  28'd4499999,  28'd5999999,  28'd8999999,
    28'd12999999, 28'd16999999, 28'd19999999, 28'd22999999,
    28'd26999999, 28'd39999999, 28'd60000000
  };

  // floor(0.23 V * (band + 1) * 84)
  localparam logic [7:0] DAC_CODE [TableBands] = '{
    8'd19, 8'd38, 8'd57, 8'd77, 8'd96, 8'd115,
    8'd135, 8'd154, 8'd173, 8'd193, 8'd212
  };

  typedef struct packed {
    logic             ok;
    logic [FreqW-1:0] freq;
  } frame_rec_t;

  function automatic logic [26:0] digit_weight(input logic [2:0] idx);
    logic [26:0] w;
    case (idx)
      3'd0:    w = 27'd1;
      3'd1:    w = 27'd100;
      3'd2:    w = 27'd10000;
      3'd3:    w = 27'd1000000;
      3'd4:    w = 27'd100000000;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/cfbd_front.sv
// Front end: frame parser, command capture and BCD frequency accumulation.
`include "civ_frequency_band_decoder_assert.svh"

module cfbd_front #(
  parameter int unsigned FREQ_BYTES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                q_full_i,
  output logic                push_o,
  output cfbd_pkg::frame_rec_t rec_o
);
  import cfbd_pkg::*;

  localparam logic [2:0] NumDigits = 3'(FREQ_BYTES);

  logic [3:0]       pos_q, pos_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [FreqW-1:0] acc_q, acc_d;
  logic [2:0]       dig_q, dig_d;

  logic             accept;
  logic             term;
  logic             ok;
  logic [7:0]       digit_val;
  logic [34:0]      product;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign term       = (rx_byte_i == TERMINATOR);
  assign ok         = (cmd_q == FREQ_COMMAND) && (dig_q >= NumDigits);

  assign digit_val = ({4'd0, rx_byte_i[7:4]} * 8'd10) + {4'd0, rx_byte_i[3:0]};
  assign product   = 35'(digit_val) * 35'(digit_weight(dig_q));

  assign push_o    = accept && term;
  assign rec_o.ok   = ok;
  assign rec_o.freq = ok ? acc_q : '0;

  always_comb begin
    pos_d = pos_q;
    cmd_d = cmd_q;
    acc_d = acc_q;
    dig_d = dig_q;
    if (accept) begin
      if (term) begin
        pos_d = '0;
        cmd_d = '0;
        acc_d = '0;
        dig_d = '0;
      end else begin
        if (pos_q == CMD_POS) begin
          cmd_d = rx_byte_i;
        end
        if ((pos_q >= FIRST_DIG_POS) && (dig_q < NumDigits)) begin
          acc_d = acc_q + product[FreqW-1:0];
          dig_d = dig_q + 3'd1;
        end
        if (pos_q < POS_MAX) begin
          pos_d = pos_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cmd_q <= '0;
      acc_q <= '0;
      dig_q <= '0;
    end else begin
      pos_q <= pos_d;
      cmd_q <= cmd_d;
      acc_q <= acc_d;
      dig_q <= dig_d;
    end
  end

  `CFBD_ASSERT(a_digits_bounded, 1'b1, dig_q <= NumDigits)
  `CFBD_ASSERT_NEXT(a_frame_cleared, push_o, (pos_q == '0) && (dig_q == '0) && (acc_q == '0))

endmodule

// File: rtl/core/cfbd_queue.sv
// Two-entry queue of decoded frame records between front and back end.
`include "civ_frequency_band_decoder_assert.svh"

module cfbd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cfbd_pkg::frame_rec_t rec_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output cfbd_pkg::frame_rec_t rec_o
);
  import cfbd_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  frame_rec_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PtrW'(1) : wr_q;
    rd_d  = pop_i  ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  `CFBD_ASSERT(a_no_overflow, push_i, !full_o || pop_i)
  `CFBD_ASSERT(a_no_underflow, pop_i, valid_o)

endmodule

// File: rtl/core/cfbd_back.sv
// Back end: band lookup, DAC code and registered result output.
`include "civ_frequency_band_decoder_assert.svh"

module cfbd_back #(
  parameter int unsigned BAND_COUNT = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  cfbd_pkg::frame_rec_t         rec_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         is_frequency_o,
  output logic [cfbd_pkg::FreqW-1:0]   frequency_hz_o,
  output logic [3:0]                   band_number_o,
  output logic [7:0]                   dac_code_o
);
  import cfbd_pkg::*;

  logic             valid_q, valid_d;
  logic             ok_q;
  logic [FreqW-1:0] freq_q;
  logic [3:0]       band_q, band_d;
  logic [7:0]       code_q, code_d;

  assign pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    band_d = NO_BAND;
    code_d = '0;
    if (rec_i.ok) begin
      for (int i = TableBands - 1; i >= 0; i--) begin
        if ((i < BAND_COUNT) && (rec_i.freq >= BAND_LOW[i]) &&
            (rec_i.freq <= BAND_HIGH[i])) begin
          band_d = 4'(i);
          code_d = DAC_CODE[i];
        end
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q   <= rec_i.ok;
      freq_q <= rec_i.freq;
      band_q <= band_d;
      code_q <= code_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign is_frequency_o = ok_q;
  assign frequency_hz_o = freq_q;
  assign band_number_o  = band_q;
  assign dac_code_o     = code_q;

  `CFBD_ASSERT_NEXT(a_skip_no_band, pop_o && !rec_i.ok,
                    (band_number_o == NO_BAND) && (dac_code_o == '0))

endmodule

// File: rtl/core/civ_frequency_band_decoder.sv
// Top level of the radio control stream frequency band decoder.
// One received byte is taken per cycle while the record queue is not full.
// Each frame terminator (0xFD) yields one result, queued as a record and then
// registered by the back end; the two-entry queue between the frame parser and
// the band lookup lets up to two finished results wait on a stalled output
// while bytes keep flowing. Non-terminator bytes produce no transaction. Results
// carry the decoded BCD frequency, the matched band and its 8-bit DAC code.
module civ_frequency_band_decoder #(
  parameter int unsigned BAND_COUNT = 11,
  parameter int unsigned FREQ_BYTES = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_frequency_o,
  output logic [cfbd_pkg::FreqW-1:0] frequency_hz_o,
  output logic [3:0]                 band_number_o,
  output logic [7:0]                 dac_code_o
);
  import cfbd_pkg::*;

  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  frame_rec_t front_rec;
  frame_rec_t q_rec;

  cfbd_front #(
    .FREQ_BYTES(FREQ_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .rx_byte_i (rx_byte_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .rec_o     (front_rec)
  );

  cfbd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (front_rec),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rec_o  (q_rec)
  );

  cfbd_back #(
    .BAND_COUNT(BAND_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .rec_i         (q_rec),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_frequency_o(is_frequency_o),
    .frequency_hz_o(frequency_hz_o),
    .band_number_o (band_number_o),
    .dac_code_o    (dac_code_o)
  );

endmodule

// File: dv/civ_frequency_band_decoder_chk.sv
// Checker for the frequency band decoder: tracks frames, predicts results, compares them.
`timescale 1ns / 100ps
module civ_frequency_band_decoder_chk #(
  parameter int unsigned BAND_COUNT = 11,
  parameter int unsigned FREQ_BYTES = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [7:0]                 rx_byte_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       is_frequency_i,
  input  logic [cfbd_pkg::FreqW-1:0] frequency_hz_i,
  input  logic [3:0]                 band_number_i,
  input  logic [7:0]                 dac_code_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         decoded_o,
  output int                         skipped_o,
  output int                         unbanded_o
);
  import cfbd_pkg::*;

  typedef struct packed {
    logic             is_freq;
    logic [FreqW-1:0] freq;
    logic [3:0]       band;
    logic [7:0]       dac;
  } band_result_t;

  localparam logic [FreqW-1:0] BandStart [11] = '{
    28'd800000, 28'd3000000, 28'd4500000, 28'd6000000, 28'd9000000, 28'd13000000,
    28'd17000000, 28'd20000000, 28'd23000000, 28'd27000000, 28'd40000000
  };
  localparam logic [FreqW-1:0] BandEnd [11] = '{
    28'd2999999, 28'd4499999, 28'd5999999, 28'd8999999, 28'd12999999, 28'd16999999,
    28'd19999999, 28'd22999999, 28'd26999999, 28'd39999999, 28'd60000000
  };

  logic [3:0]       frame_pos;
  logic [7:0]       cmd_byte;
  logic [FreqW-1:0] freq_acc;
  logic [2:0]       bcd_count;

  band_result_t expected_bands_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int decoded = 0;
  int skipped = 0;
  int unbanded = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    decoded_o    = 0;
    skipped_o    = 0;
    unbanded_o   = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic band_result_t classify_frame(input logic ok, input logic [FreqW-1:0] freq);
    band_result_t r;
    logic         found;
    r.is_freq = ok;
    r.freq    = ok ? freq : '0;
    r.band    = NO_BAND;
    r.dac     = '0;
    found     = 1'b0;
    if (ok) begin
      for (int i = 0; i < BAND_COUNT && i < 11; i++) begin
        if (!found && freq >= BandStart[i] && freq <= BandEnd[i]) begin
          found = 1'b1;
          r.band = 4'(i);
          r.dac  = 8'((23 * (i + 1) * 84) / 100);
        end
      end
    end
    return r;
  endfunction

  task automatic track_byte(input logic [7:0] b);
    logic [39:0] weight;
    logic [39:0] sum;
    if (b == TERMINATOR) begin
      expected_bands_q.push_back(classify_frame(
        cmd_byte == FREQ_COMMAND && bcd_count >= FREQ_BYTES, freq_acc));
      frame_pos = '0;
      cmd_byte  = '0;
      freq_acc  = '0;
      bcd_count = '0;
    end else begin
      if (frame_pos == CMD_POS) cmd_byte = b;
      if (frame_pos >= FIRST_DIG_POS && bcd_count < FREQ_BYTES && bcd_count < 5) begin
        weight = 40'd1;
        repeat (bcd_count) weight = weight * 40'd100;
        sum = 40'(freq_acc) + (40'(b[7:4]) * 40'd10 + 40'(b[3:0])) * weight;
        freq_acc  = sum[FreqW-1:0];
        bcd_count = bcd_count + 3'd1;
      end
      if (frame_pos < POS_MAX) frame_pos = frame_pos + 4'd1;
    end
  endtask

  task automatic check_result();
    band_result_t want;
    results_seen++;
    if (expected_bands_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = expected_bands_q.pop_front();
      if (is_frequency_i !== want.is_freq)
        report_mismatch($sformatf("result %0d is_frequency: expected %0d, got %0d",
                                  results_seen, want.is_freq, is_frequency_i));
      if (frequency_hz_i !== want.freq)
        report_mismatch($sformatf("result %0d frequency_hz: expected %0d, got %0d",
                                  results_seen, want.freq, frequency_hz_i));
      if (band_number_i !== want.band)
        report_mismatch($sformatf("result %0d band_number: expected %0d, got %0d",
                                  results_seen, want.band, band_number_i));
      if (dac_code_i !== want.dac)
        report_mismatch($sformatf("result %0d dac_code: expected %0d, got %0d",
                                  results_seen, want.dac, dac_code_i));
      if (!want.is_freq) skipped++;
      else if (want.band == NO_BAND) unbanded++;
      else decoded++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos = '0;
      cmd_byte  = '0;
      freq_acc  = '0;
      bcd_count = '0;
    end else begin
      if (in_valid_i && in_ready_i) track_byte(rx_byte_i);
      if (out_valid_i && out_ready_i) check_result();
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_bands_q.size();
    decoded_o    <= decoded;
    skipped_o    <= skipped;
    unbanded_o   <= unbanded;
  end

endmodule

// File: dv/civ_frequency_band_decoder_tb.sv
// Testbench top for the frequency band decoder: byte stream stimulus, flow control and verdict.
`timescale 1ns / 100ps
module civ_frequency_band_decoder_tb;
  import cfbd_pkg::*;

  localparam int unsigned BandCount = 11;
  localparam int unsigned FreqBytes = 4;
  localparam int unsigned ByteTarget = 1900;

  typedef logic [7:0] byte_q_t[$];

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             is_frequency;
  logic [FreqW-1:0] frequency_hz;
  logic [3:0]       band_number;
  logic [7:0]       dac_code;

  int fail_count;
  int pending;
  int decoded;
  int skipped;
  int unbanded;

  int gap_pct = 14;
  int stall_pct = 47;
  int bytes_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  civ_frequency_band_decoder #(
    .BAND_COUNT(BandCount),
    .FREQ_BYTES(FreqBytes)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .is_frequency_o(is_frequency),
    .frequency_hz_o(frequency_hz),
    .band_number_o (band_number),
    .dac_code_o    (dac_code)
  );

  civ_frequency_band_decoder_chk #(
    .BAND_COUNT(BandCount),
    .FREQ_BYTES(FreqBytes)
  ) u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .is_frequency_i(is_frequency),
    .frequency_hz_i(frequency_hz),
    .band_number_i (band_number),
    .dac_code_i    (dac_code),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .decoded_o     (decoded),
    .skipped_o     (skipped),
    .unbanded_o    (unbanded)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // valid stays high across back-to-back transactions; only lowered for a gap or to drain results
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic play_frame(input byte_q_t fr);
    foreach (fr[i]) push_byte(fr[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == TERMINATOR) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic int unsigned pick_frequency();
    int unsigned band;
    int unsigned f;
    band = $urandom_range(BandCount - 1);
    case ($urandom_range(5))
      0:       f = 32'(BAND_LOW[band]);
      1:       f = 32'(BAND_HIGH[band]);
      2:       f = 32'(BAND_LOW[band]) - 1;
      3:       f = 32'(BAND_HIGH[band]) + 1;
      4:       f = $urandom_range(32'(BAND_HIGH[band]), 32'(BAND_LOW[band]));
      default: f = $urandom_range(99999999);
    endcase
    return f;
  endfunction

  task automatic random_frame();
    byte_q_t     fr;
    int unsigned kind;
    int unsigned f;
    int unsigned keep;
    int unsigned extra;
    logic        raw_digits;
    kind = $urandom_range(99);
    if (kind < 85) begin
      fr = '{8'hFE, 8'hFE, plain_byte()};
      fr.push_back(($urandom_range(99) < 88) ? FREQ_COMMAND : plain_byte());
      fr.push_back(plain_byte());
      f = pick_frequency();
      raw_digits = ($urandom_range(99) < 15);
      for (int k = 0; k < FreqBytes; k++) begin
        if (raw_digits) fr.push_back(plain_byte());
        else fr.push_back({4'((f % 100) / 10), 4'(f % 10)});
        f = f / 100;
      end
      extra = ($urandom_range(99) < 80) ? 0 : $urandom_range(9, 1);
      repeat (extra) fr.push_back(plain_byte());
      // broken frame: terminator arrives early
      if (kind >= 70) begin
        keep = $urandom_range(9);
        while (fr.size() > keep) void'(fr.pop_back());
      end
    end else begin
      repeat ($urandom_range(20, 1)) fr.push_back(8'($urandom_range(255)));
    end
    fr.push_back(TERMINATOR);
    play_frame(fr);
  endtask

  initial begin
    #4_000_000;
    $display("civ_frequency_band_decoder verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frame, terminator at the command slot, max nibbles, lowest band edge
    play_frame('{TERMINATOR});
    play_frame('{8'hFE, 8'hFE, 8'h00, TERMINATOR});
    play_frame('{8'hFE, 8'hFE, 8'hE0, FREQ_COMMAND, 8'h00,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, TERMINATOR});
    play_frame('{8'hFE, 8'hFE, 8'hE0, FREQ_COMMAND, 8'h00,
                 8'h00, 8'h00, 8'h80, 8'h00, TERMINATOR});

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin gap_pct = 14; stall_pct = 47; end
        1: begin gap_pct = 47; stall_pct = 14; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      while (bytes_sent < ByteTarget * (phase + 1) / 3) random_frame();
      drain_results();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d bytes over three flow-control phases: %0d in-band frames,",
             bytes_sent, decoded);
    $display("%0d frames outside every band and %0d skipped frames.", unbanded, skipped);
    if (fail_count == 0) begin
      $display("civ_frequency_band_decoder verification clean");
    end else begin
      $display("civ_frequency_band_decoder verification failed");
    end
    $finish;
  end

endmodule
